// File: rtl/energy_voice_activity_detector_core_macros.svh
// Assertion helpers, clocked on clk, held off while rst_n is low.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define EVAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evad check failed");

// next-cycle implication
`define EVAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evad check failed");

`endif

// File: rtl/evad_pkg.sv
`timescale 1ns / 1ps
package evad_pkg;

  localparam int WINDOW_MAX_DEF = 2048;
  localparam int SENS_LEVELS    = 4;
  localparam int CNT_LIM_W      = 13;
  localparam int SUM_LIM_W      = 29;

  localparam logic [2:0] CFG_SENS   = 3'd0;
  localparam logic [2:0] CFG_ONSET  = 3'd1;
  localparam logic [2:0] CFG_HANG   = 3'd2;
  localparam logic [2:0] CFG_CALW   = 3'd3;
  localparam logic [2:0] CFG_CALM   = 3'd4;
  localparam logic [2:0] CFG_MINTHR = 3'd5;
  localparam logic [2:0] CFG_FBTHR  = 3'd6;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  typedef struct packed {
    logic [1:0]  sensitivity;
    logic [3:0]  onset_windows;
    logic [15:0] hangover_ms;
    logic [7:0]  calibration_windows;
    logic [3:0]  calibration_multiplier;
    logic [14:0] min_threshold;
    logic [14:0] fallback_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CNT_LIM_W-1:0]        cnt;
    logic signed [SUM_LIM_W-1:0] sum;
    logic [31:0]                 ms;
  } job_t;

  typedef struct packed {
    logic mem_busy;
  } status_t;

  function automatic logic [3:0] sens_mult(input logic [1:0] sel);
    logic [3:0] m;
    case (sel)
      2'd0: m = 4'd1;
      2'd1: m = 4'd2;
      2'd2: m = 4'd4;
      2'd3: m = 4'd8;
      default: m = 4'd1;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/evad_queue.sv
`timescale 1ns / 1ps
module evad_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  evad_pkg::job_t   push_job,
  input  logic             pop,
  output evad_pkg::job_t   head_job,
  output logic             empty,
  output logic             full
);
  import evad_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] lvl_r, lvl_nxt;

  assign empty    = (lvl_r == 2'd0);
  assign full     = (lvl_r == 2'd2);
  assign head_job = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    lvl_nxt = lvl_r;
    if (push && !full) begin
      wp_nxt  = ~wp_r;
      lvl_nxt = lvl_nxt + 2'd1;
    end
    if (pop && !empty) begin
      rp_nxt  = ~rp_r;
      lvl_nxt = lvl_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      lvl_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_job;
    end
  end
endmodule

// File: rtl/evad_front.sv
`timescale 1ns / 1ps
module evad_front #(
  parameter int WINDOW_MAX = evad_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic signed [15:0]            in_sample,
  input  logic                          in_last_sample,
  input  evad_pkg::status_t             bk_status,
  input  logic                          q_empty,
  output logic                          push,
  output evad_pkg::job_t                push_job,
  input  logic [$clog2(WINDOW_MAX)-1:0] rd_addr,
  output logic signed [15:0]            rd_data
);
  import evad_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = CNT_W + 16;

  logic signed [15:0]      mem [WINDOW_MAX];
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_add;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [31:0]             ms_r, ms_nxt;
  logic                    smp_ok, acc, room;

  assign smp_ok   = q_empty && !bk_status.mem_busy;
  assign in_ready = in_kind ? 1'b1 : smp_ok;
  assign acc      = in_valid && in_ready;
  assign room     = (cnt_r < CNT_W'(WINDOW_MAX));

  always_comb begin
    cnt_add = cnt_r;
    sum_add = sum_r;
    if (room) begin
      cnt_add = cnt_r + CNT_W'(1);
      sum_add = sum_r + SUM_W'(in_sample);
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    ms_nxt   = ms_r;
    push     = 1'b0;
    push_job.cnt = CNT_LIM_W'(cnt_add);
    push_job.sum = SUM_LIM_W'(sum_add);
    push_job.ms  = ms_r;
    if (acc) begin
      if (in_kind) begin
        ms_nxt = ms_r + 32'd1;
      end else if (in_last_sample) begin
        push    = 1'b1;
        cnt_nxt = '0;
        sum_nxt = '0;
      end else begin
        cnt_nxt = cnt_add;
        sum_nxt = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      ms_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      ms_r  <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_kind && room) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_sample;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/evad_div.sv
`timescale 1ns / 1ps
module evad_div #(
  parameter int DV_W = 30,
  parameter int DS_W = 13
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DV_W-1:0] dividend,
  input  logic [DS_W-1:0] divisor,
  output logic            done,
  output logic [DV_W-1:0] quotient
);
  localparam int STEP_W = $clog2(DV_W + 1);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DS_W-1:0]   rem_r, rem_nxt, div_r;
  logic [DV_W-1:0]   quo_r, quo_nxt;
  logic [DS_W:0]     rem_t;
  logic              fits;

  assign rem_t    = {rem_r, quo_r[DV_W-1]};
  assign fits     = (rem_t >= {1'b0, div_r});
  assign quotient = quo_r;
  assign done     = busy_r && (step_r == STEP_W'(DV_W));

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (step_r == STEP_W'(DV_W)) begin
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = fits ? DS_W'(rem_t - {1'b0, div_r}) : DS_W'(rem_t);
        quo_nxt  = {quo_r[DV_W-2:0], fits};
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end
endmodule

// File: rtl/evad_back.sv
`timescale 1ns / 1ps
module evad_back #(
  parameter int WINDOW_MAX = evad_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  evad_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  evad_pkg::job_t                head_job,
  output logic                          pop,
  output evad_pkg::status_t             bk_status,
  output logic [$clog2(WINDOW_MAX)-1:0] rd_addr,
  input  logic signed [15:0]            rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_energy,
  output logic                          out_speech_active,
  output logic [1:0]                    out_speech_event,
  output logic                          out_calibrating
);
  import evad_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int DEV_W  = CNT_W + 16;
  localparam int DV_W   = (CNT_W + 17 > 24) ? CNT_W + 17 : 24;
  localparam int DS_W   = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVM = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_DIVE = 3'd3;
  localparam logic [2:0] ST_DIVA = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]          st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, addr_r;
  logic                neg_r;
  logic [31:0]         ms_r;
  logic signed [16:0]  mean_r;
  logic                vld_r, issue, pass_end;
  logic [DEV_W-1:0]    dev_r;
  logic [15:0]         energy_r;
  logic                calib_r;
  logic [7:0]          done_r;
  logic [23:0]         total_r;
  logic [19:0]         base_r;
  logic [3:0]          run_r;
  logic                spk_r;
  logic [31:0]         last_r;

  logic                div_start, div_done;
  logic [DV_W-1:0]     div_a, div_q;
  logic [DS_W-1:0]     div_b;
  logic [SUM_LIM_W-1:0] mag;
  logic signed [17:0]  dlt;
  logic [16:0]         adev;
  logic [23:0]         tot_nxt;
  logic [27:0]         bprod;
  logic [22:0]         thr;
  logic                loud, slot_free;
  logic [3:0]          run1, need;
  logic                sp1;
  logic [31:0]         last1;
  logic [1:0]          ev1;
  logic [16:0]         qm;

  evad_div #(.DV_W(DV_W), .DS_W(DS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign bk_status.mem_busy = (st_r == ST_DIVM) || (st_r == ST_PASS);
  assign rd_addr  = addr_r[ADDR_W-1:0];
  assign issue    = (st_r == ST_PASS) && (addr_r < cnt_r);
  assign pass_end = (st_r == ST_PASS) && !issue && !vld_r;
  assign pop      = (st_r == ST_IDLE) && !q_empty;
  assign mag      = head_job.sum[SUM_LIM_W-1] ? SUM_LIM_W'(-head_job.sum)
                                              : SUM_LIM_W'(head_job.sum);
  assign dlt      = 18'(rd_data) - 18'(mean_r);
  assign adev     = dlt[17] ? 17'(-dlt) : 17'(dlt);
  assign tot_nxt  = total_r + 24'(div_q[15:0]);
  assign qm       = 17'(div_q);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    div_start = 1'b0;
    div_a     = DV_W'(mag);
    div_b     = DS_W'(head_job.cnt);
    if (pop) begin
      div_start = 1'b1;
    end else if (pass_end) begin
      div_start = 1'b1;
      div_a     = DV_W'(dev_r);
      div_b     = DS_W'(cnt_r);
    end else if ((st_r == ST_DIVE) && div_done && (done_r < cfg.calibration_windows)
                 && (done_r + 8'd1 == cfg.calibration_windows)) begin
      div_start = 1'b1;
      div_a     = DV_W'(tot_nxt);
      div_b     = DS_W'(cfg.calibration_windows);
    end
  end

  always_comb begin
    bprod = div_q[23:0] * cfg.calibration_multiplier;
    thr   = (base_r != 20'd0) ? 23'(base_r) * 23'(sens_mult(cfg.sensitivity))
                              : 23'(cfg.fallback_threshold);
    loud  = 23'(energy_r) > thr;
    need  = (cfg.onset_windows == 4'd0) ? 4'd1 : cfg.onset_windows;
    run1  = loud ? ((run_r == 4'd15) ? 4'd15 : run_r + 4'd1) : 4'd0;
    last1 = loud ? ms_r : last_r;
    sp1   = spk_r;
    ev1   = EV_NONE;
    if (!sp1 && run1 >= need) begin
      sp1 = 1'b1;
      ev1 = EV_START;
    end
    if (sp1 && !loud && (ms_r - last1) > 32'(cfg.hangover_ms)) begin
      sp1  = 1'b0;
      run1 = 4'd0;
      ev1  = EV_END;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (pop) st_nxt = ST_DIVM;
      ST_DIVM: if (div_done) st_nxt = ST_PASS;
      ST_PASS: if (pass_end) st_nxt = ST_DIVE;
      ST_DIVE: if (div_done) st_nxt = div_start ? ST_DIVA : ST_FIN;
      ST_DIVA: if (div_done) st_nxt = ST_FIN;
      ST_FIN:  if (slot_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      vld_r     <= 1'b0;
      done_r    <= '0;
      total_r   <= '0;
      base_r    <= '0;
      run_r     <= '0;
      spk_r     <= 1'b0;
      last_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= issue;
      if ((st_r == ST_DIVE) && div_done && (done_r < cfg.calibration_windows)) begin
        done_r  <= done_r + 8'd1;
        total_r <= tot_nxt;
      end
      if ((st_r == ST_DIVA) && div_done) begin
        base_r <= (bprod > 28'(cfg.min_threshold)) ? bprod[19:0]
                                                  : 20'(cfg.min_threshold);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((st_r == ST_FIN) && slot_free) begin
        out_valid <= 1'b1;
        if (!calib_r) begin
          run_r  <= run1;
          spk_r  <= sp1;
          last_r <= last1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cnt_r <= CNT_W'(head_job.cnt);
      neg_r <= head_job.sum[SUM_LIM_W-1];
      ms_r  <= head_job.ms;
    end
    if ((st_r == ST_DIVM) && div_done) begin
      mean_r <= neg_r ? -$signed(qm) : $signed(qm);
      addr_r <= '0;
      dev_r  <= '0;
    end
    if (issue) begin
      addr_r <= addr_r + CNT_W'(1);
    end
    if (vld_r) begin
      dev_r <= dev_r + DEV_W'(adev);
    end
    if ((st_r == ST_DIVE) && div_done) begin
      energy_r <= div_q[15:0];
      calib_r  <= (done_r < cfg.calibration_windows);
    end
    if ((st_r == ST_FIN) && slot_free) begin
      out_energy        <= energy_r;
      out_calibrating   <= calib_r;
      out_speech_active <= calib_r ? spk_r : sp1;
      out_speech_event  <= calib_r ? EV_NONE : ev1;
    end
  end
endmodule

// File: rtl/energy_voice_activity_detector_core.sv
`timescale 1ns / 1ps
// Energy voice activity detector.
// Input channel (in_valid/in_ready): one beat is either a 1 ms tick (in_kind=1,
// always taken at once) or a PCM sample; a sample with in_last_sample closes
// the window. Up to WINDOW_MAX samples are kept per window, the rest ignored.
// Output channel (out_valid/out_ready): one beat per closed window with the
// window energy, speech state, start/end event and calibration flag.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index picks the
// register, cfg_data its value; write only while the block is idle.
// Samples are accepted while the queue is empty and the back end is free of the
// window memory. At window close the back end does a serial mean division
// (divider width 29 bits at the default size), a memory pass over the stored
// samples, a second division, and at the end of calibration a third; then the
// result is registered. New samples wait until the back end has popped the
// window and finished the mean and memory pass; ticks are never held up.
// A stalled receiver holds the result; the block finishes the next window and
// waits with it until the output register frees.
// Reset (rst_n low, synchronous) clears counters, calibration and speech state.
module energy_voice_activity_detector_core #(
  parameter int WINDOW_MAX = evad_pkg::WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [15:0] in_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_energy,
  output logic               out_speech_active,
  output logic [1:0]         out_speech_event,
  output logic               out_calibrating,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import evad_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_MAX);

  cfg_t               cfg_r;
  status_t            bk_status;
  job_t               push_job, head_job;
  logic               push, pop, q_empty, q_full;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [15:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensitivity            <= 2'd0;
      cfg_r.onset_windows          <= 4'd2;
      cfg_r.hangover_ms            <= 16'd300;
      cfg_r.calibration_windows    <= 8'd30;
      cfg_r.calibration_multiplier <= 4'd2;
      cfg_r.min_threshold          <= 15'd80;
      cfg_r.fallback_threshold     <= 15'd80;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SENS:   cfg_r.sensitivity            <= cfg_data[1:0];
        CFG_ONSET:  cfg_r.onset_windows          <= cfg_data[3:0];
        CFG_HANG:   cfg_r.hangover_ms            <= cfg_data;
        CFG_CALW:   cfg_r.calibration_windows    <= cfg_data[7:0];
        CFG_CALM:   cfg_r.calibration_multiplier <= cfg_data[3:0];
        CFG_MINTHR: cfg_r.min_threshold          <= cfg_data[14:0];
        CFG_FBTHR:  cfg_r.fallback_threshold     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  evad_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .bk_status      (bk_status),
    .q_empty        (q_empty),
    .push           (push),
    .push_job       (push_job),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  evad_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  evad_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty || (q_full && 1'b0)),
    .head_job          (head_job),
    .pop               (pop),
    .bk_status         (bk_status),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy        (out_energy),
    .out_speech_active (out_speech_active),
    .out_speech_event  (out_speech_event),
    .out_calibrating   (out_calibrating)
  );
endmodule

// File: rtl/evad_chk.sv
`timescale 1ns / 1ps
`include "energy_voice_activity_detector_core_macros.svh"
module evad_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_energy,
  input logic        out_speech_active,
  input logic [1:0]  out_speech_event,
  input logic        out_calibrating
);
  import evad_pkg::*;

  `EVAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_energy))
  `EVAD_ASSERT_NOW(a_calib_quiet, out_valid && out_calibrating, out_speech_event == EV_NONE)
  `EVAD_ASSERT_NOW(a_start_active, out_valid && out_speech_event == EV_START, out_speech_active)
  `EVAD_ASSERT_NOW(a_end_idle, out_valid && out_speech_event == EV_END, !out_speech_active)
endmodule

bind energy_voice_activity_detector_core evad_chk u_evad_chk (.*);
